>>> sv/ppad_pkg.sv
// ---------------------------------------------------------------------------
// ppad_pkg
// Shared types, widths and constants for the point pair angle and distance
// pipeline: word formats, stage record, arctangent table and output scaling.
// ---------------------------------------------------------------------------
package ppad_pkg;

   // field widths
   localparam int COORD_BITS      = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ANGLE_BITS      = 16;
   localparam int DIST_BITS       = 17;

   // front end widths
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int MSB_BITS   = $clog2(DIFF_BITS);
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int ROOT_BITS  = SUM_BITS + 1;
   localparam int SQRT_STEPS = (SUM_BITS + 1) / 2;

   // vectoring datapath: larger magnitude normalised to at least 2^40
   localparam int NORM_TARGET  = 40;
   localparam int SHIFT_BITS   = $clog2(NORM_TARGET + 1);
   localparam int XY_BITS      = NORM_TARGET + 5;
   localparam int CORDIC_STEPS = 32;
   localparam int TURN_BITS    = 32;

   // pipeline depth
   localparam int PREP_STAGES  = 3;
   localparam int SCALE_STAGES = 2;
   localparam int LATENCY      = PREP_STAGES + CORDIC_STEPS + SCALE_STAGES;

   // angle unit codes
   localparam logic UNIT_RADIANS = 1'b0;
   localparam logic UNIT_DEGREES = 1'b1;

   // binary turn to output unit scaling
   localparam int PROD_BITS = 2 * TURN_BITS;
   localparam int RND_BITS  = PROD_BITS + 1;
   localparam logic [TURN_BITS-1:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [TURN_BITS-1:0] DEG_SCALE  = 32'd45;
   localparam int RAD_SHIFT = 61 - ANGLE_FRAC_BITS;
   localparam int DEG_SHIFT = 29 - (ANGLE_FRAC_BITS - 6);
   localparam logic [RND_BITS-1:0] RAD_HALF = RND_BITS'(1) << (RAD_SHIFT - 1);
   localparam logic [RND_BITS-1:0] DEG_HALF = RND_BITS'(1) << (DEG_SHIFT - 1);
   localparam logic [RND_BITS-1:0] RAD_FULL =
      ((RND_BITS'(TWO_PI_Q29) << TURN_BITS) + RAD_HALF) >> RAD_SHIFT;
   localparam logic [RND_BITS-1:0] DEG_FULL =
      (RND_BITS'(DEG_SCALE) << TURN_BITS) >> DEG_SHIFT;

   // distance ceiling
   localparam logic [ROOT_BITS-1:0] DIST_MAX = ROOT_BITS'((65'd1 << DIST_BITS) - 65'd1);

   // request word
   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
   } ppad_req_type;

   // response word
   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle;
      logic [DIST_BITS-1:0]  distance;
      logic                  coincident;
   } ppad_rsp_type;

   // record carried from stage to stage
   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic [TURN_BITS-1:0]      acc;
      logic [SUM_BITS-1:0]       rem;
      logic [ROOT_BITS-1:0]      root;
      logic                      coincident;
   } ppad_stage_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [TURN_BITS-1:0] atan_turn(input int step);
      logic [TURN_BITS-1:0] val;
      case (step)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         24:      val = 32'h00000029;
         25:      val = 32'h00000014;
         26:      val = 32'h0000000A;
         27:      val = 32'h00000005;
         28:      val = 32'h00000003;
         29:      val = 32'h00000001;
         30:      val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

>>> sv/ppad_prep.sv
// ---------------------------------------------------------------------------
// ppad_prep
// Front end: coordinate differences, half-plane fold, squares for the
// distance and normalising shift of the vector, over three register stages.
// ---------------------------------------------------------------------------
module ppad_prep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ppad_pkg::ppad_req_type   in_word,
   output logic                     out_valid,
   output ppad_pkg::ppad_stage_type out_data
);

   // stage a: differences
   logic                                      valid_a_ff;
   logic signed [ppad_pkg::DIFF_BITS-1:0]     dx_in, dx_ff;
   logic signed [ppad_pkg::DIFF_BITS-1:0]     up_in, up_ff;

   // stage b: folded vector, squares, shift
   logic                                      valid_b_ff;
   logic signed [ppad_pkg::DIFF_BITS-1:0]     x0_in, x0_ff;
   logic signed [ppad_pkg::DIFF_BITS-1:0]     y0_in, y0_ff;
   logic [ppad_pkg::DIFF_BITS-1:0]            ax, ay, mag;
   logic [ppad_pkg::MSB_BITS-1:0]             msb;
   logic [ppad_pkg::SHIFT_BITS-1:0]           sh_in, sh_ff;
   logic [ppad_pkg::SQ_BITS-1:0]              ax_sq_in, ax_sq_ff;
   logic [ppad_pkg::SQ_BITS-1:0]              ay_sq_in, ay_sq_ff;
   logic                                      half_in, half_ff;
   logic                                      coinc_in, coinc_ff;

   // stage c: first stage record
   logic                                      valid_c_ff;
   ppad_pkg::ppad_stage_type                  data_in, data_ff;

   // differences, screen y flipped to point up
   assign dx_in = ppad_pkg::DIFF_BITS'(in_word.point_x) - ppad_pkg::DIFF_BITS'(in_word.origin_x);
   assign up_in = ppad_pkg::DIFF_BITS'(in_word.origin_y) - ppad_pkg::DIFF_BITS'(in_word.point_y);

   // fold the left half-plane onto the right, start half a turn round
   always_comb begin
      half_in  = dx_ff[ppad_pkg::DIFF_BITS-1];
      x0_in    = half_in ? -dx_ff : dx_ff;
      y0_in    = half_in ? -up_ff : up_ff;
      ax       = ppad_pkg::DIFF_BITS'(x0_in);
      ay       = up_ff[ppad_pkg::DIFF_BITS-1] ? ppad_pkg::DIFF_BITS'(-up_ff)
                                              : ppad_pkg::DIFF_BITS'(up_ff);
      coinc_in = (dx_ff == '0) && (up_ff == '0);
      ax_sq_in = ppad_pkg::SQ_BITS'(ax) * ppad_pkg::SQ_BITS'(ax);
      ay_sq_in = ppad_pkg::SQ_BITS'(ay) * ppad_pkg::SQ_BITS'(ay);
   end

   // leading one of the larger magnitude sets the normalising shift
   always_comb begin
      mag = (ax > ay) ? ax : ay;
      msb = '0;
      for (int i = 0; i < ppad_pkg::DIFF_BITS; i++) begin
         if (mag[i]) begin
            msb = ppad_pkg::MSB_BITS'(i);
         end
      end
      sh_in = ppad_pkg::SHIFT_BITS'(ppad_pkg::NORM_TARGET) - ppad_pkg::SHIFT_BITS'(msb);
   end

   // normalised vector and sum of squares
   always_comb begin
      data_in            = '0;
      data_in.x          = ppad_pkg::XY_BITS'(x0_ff) <<< sh_ff;
      data_in.y          = ppad_pkg::XY_BITS'(y0_ff) <<< sh_ff;
      data_in.acc        = {half_ff, {(ppad_pkg::TURN_BITS-1){1'b0}}};
      data_in.rem        = ppad_pkg::SUM_BITS'(ax_sq_ff) + ppad_pkg::SUM_BITS'(ay_sq_ff);
      data_in.root       = '0;
      data_in.coincident = coinc_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      up_ff    <= up_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      sh_ff    <= sh_in;
      ax_sq_ff <= ax_sq_in;
      ay_sq_ff <= ay_sq_in;
      half_ff  <= half_in;
      coinc_ff <= coinc_in;
      data_ff  <= data_in;
   end

   assign out_valid = valid_c_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/ppad_stage.sv
// ---------------------------------------------------------------------------
// ppad_stage
// One vectoring rotation with its angle update, plus one digit of the
// square root, its final rounding or a pass through for the distance.
// ---------------------------------------------------------------------------
module ppad_stage #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ppad_pkg::ppad_stage_type in_data,
   output logic                     out_valid,
   output ppad_pkg::ppad_stage_type out_data
);

   localparam logic [ppad_pkg::TURN_BITS-1:0] ATAN_STEP = ppad_pkg::atan_turn(STEP);

   logic                               valid_ff;
   ppad_pkg::ppad_stage_type           data_in, data_ff;
   logic signed [ppad_pkg::XY_BITS-1:0] xs, ys;
   logic [ppad_pkg::SUM_BITS-1:0]      rem_in;
   logic [ppad_pkg::ROOT_BITS-1:0]     root_in;

   // rotate towards the x axis, direction from the sign of y
   always_comb begin
      xs      = in_data.x >>> STEP;
      ys      = in_data.y >>> STEP;
      data_in = in_data;
      if (!in_data.y[ppad_pkg::XY_BITS-1]) begin
         data_in.x   = in_data.x + ys;
         data_in.y   = in_data.y - xs;
         data_in.acc = in_data.acc + ATAN_STEP;
      end else begin
         data_in.x   = in_data.x - ys;
         data_in.y   = in_data.y + xs;
         data_in.acc = in_data.acc - ATAN_STEP;
      end
      data_in.rem  = rem_in;
      data_in.root = root_in;
   end

   // square root digit, rounding, or pass through
   if (STEP < ppad_pkg::SQRT_STEPS) begin : g_root
      localparam logic [ppad_pkg::ROOT_BITS-1:0] BIT_VAL =
         ppad_pkg::ROOT_BITS'(1) << (2 * (ppad_pkg::SQRT_STEPS - 1 - STEP));
      logic [ppad_pkg::ROOT_BITS-1:0] trial;
      assign trial = in_data.root + BIT_VAL;
      always_comb begin
         if (ppad_pkg::ROOT_BITS'(in_data.rem) >= trial) begin
            rem_in  = in_data.rem - ppad_pkg::SUM_BITS'(trial);
            root_in = (in_data.root >> 1) + BIT_VAL;
         end else begin
            rem_in  = in_data.rem;
            root_in = in_data.root >> 1;
         end
      end
   end else if (STEP == ppad_pkg::SQRT_STEPS) begin : g_round
      logic [ppad_pkg::ROOT_BITS-1:0] rounded;
      // round to nearest: the remainder beyond the root means past the half
      always_comb begin
         rounded = (ppad_pkg::ROOT_BITS'(in_data.rem) > in_data.root) ?
                   in_data.root + ppad_pkg::ROOT_BITS'(1) : in_data.root;
         root_in = (rounded > ppad_pkg::DIST_MAX) ? ppad_pkg::DIST_MAX : rounded;
         rem_in  = in_data.rem;
      end
   end else begin : g_pass
      assign rem_in  = in_data.rem;
      assign root_in = in_data.root;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/ppad_scale.sv
// ---------------------------------------------------------------------------
// ppad_scale
// Converts the binary turn angle to radians or degrees with rounding and
// wrap at a full turn, and builds the response word.
// ---------------------------------------------------------------------------
module ppad_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ppad_pkg::ppad_stage_type in_data,
   input  logic                     angle_unit,
   output logic                     out_strobe,
   output ppad_pkg::ppad_rsp_type   out_word
);

   // stage 1: product
   logic                               valid_p_ff;
   logic [ppad_pkg::TURN_BITS-1:0]     mult;
   logic [ppad_pkg::PROD_BITS-1:0]     prod_in, prod_ff;
   logic                               deg_ff;
   logic                               coinc_ff;
   logic [ppad_pkg::DIST_BITS-1:0]     dist_ff;

   // stage 2: rounding and response
   logic                               valid_r_ff;
   logic [ppad_pkg::RND_BITS-1:0]      rad_q, deg_q;
   logic [ppad_pkg::ANGLE_BITS-1:0]    rad_ang, deg_ang;
   ppad_pkg::ppad_rsp_type             rsp_in, rsp_ff;

   // scale factor follows the unit register
   always_comb begin
      mult    = (angle_unit == ppad_pkg::UNIT_DEGREES) ? ppad_pkg::DEG_SCALE
                                                       : ppad_pkg::TWO_PI_Q29;
      prod_in = ppad_pkg::PROD_BITS'(in_data.acc) * ppad_pkg::PROD_BITS'(mult);
   end

   // round half up, a full turn wraps to zero
   always_comb begin
      rad_q   = (ppad_pkg::RND_BITS'(prod_ff) + ppad_pkg::RAD_HALF) >> ppad_pkg::RAD_SHIFT;
      deg_q   = (ppad_pkg::RND_BITS'(prod_ff) + ppad_pkg::DEG_HALF) >> ppad_pkg::DEG_SHIFT;
      rad_ang = (rad_q >= ppad_pkg::RAD_FULL) ? '0 : rad_q[ppad_pkg::ANGLE_BITS-1:0];
      deg_ang = (deg_q >= ppad_pkg::DEG_FULL) ? '0 : deg_q[ppad_pkg::ANGLE_BITS-1:0];
      rsp_in.coincident = coinc_ff;
      if (coinc_ff) begin
         rsp_in.angle    = '0;
         rsp_in.distance = '0;
      end else begin
         rsp_in.angle    = deg_ff ? deg_ang : rad_ang;
         rsp_in.distance = dist_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p_ff <= 1'b0;
         valid_r_ff <= 1'b0;
      end else begin
         valid_p_ff <= in_valid;
         valid_r_ff <= valid_p_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      deg_ff   <= (angle_unit == ppad_pkg::UNIT_DEGREES);
      coinc_ff <= in_data.coincident;
      dist_ff  <= in_data.root[ppad_pkg::DIST_BITS-1:0];
      rsp_ff   <= rsp_in;
   end

   assign out_strobe = valid_r_ff;
   assign out_word   = rsp_ff;

endmodule

>>> sv/point_pair_angle_and_distance.sv
// ---------------------------------------------------------------------------
// point_pair_angle_and_distance
// Direction (full circle, from +X towards screen-up) and rounded distance
// from an origin to a point, via an unrolled vectoring pipeline.
// ---------------------------------------------------------------------------
// pipeline: a word passes 3 front end stages, 32 rotation stages and
//   2 scaling stages before the response strobe
// throughput: one word per cycle, set by the fully unrolled rotation chain;
//   busy is low whenever reset is low and the response side never stalls
// reset: synchronous, clears every valid bit and selects radians; words in
//   flight are dropped
module point_pair_angle_and_distance (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ppad_pkg::ppad_req_type req_word,
   output logic                   rsp_strobe,
   output ppad_pkg::ppad_rsp_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   logic                              angle_unit_in, angle_unit_ff;
   logic [ppad_pkg::CORDIC_STEPS:0]   chain_valid;
   ppad_pkg::ppad_stage_type          chain_data [ppad_pkg::CORDIC_STEPS+1];

   // no words taken during reset
   assign busy = reset;

   // unit register
   assign angle_unit_in = csr_wr_en ? csr_wr_data : angle_unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_unit_ff <= ppad_pkg::UNIT_RADIANS;
      end else begin
         angle_unit_ff <= angle_unit_in;
      end
   end

   // front end
   ppad_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_word   (req_word),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // rotation chain
   for (genvar i = 0; i < ppad_pkg::CORDIC_STEPS; i++) begin : g_stage
      ppad_stage #(
         .STEP (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // unit scaling and response register
   ppad_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[ppad_pkg::CORDIC_STEPS]),
      .in_data    (chain_data[ppad_pkg::CORDIC_STEPS]),
      .angle_unit (angle_unit_ff),
      .out_strobe (rsp_strobe),
      .out_word   (rsp_word)
   );

endmodule

>>> sv/ppad_checker.sv
// ---------------------------------------------------------------------------
// ppad_checker
// Port level checks of the angle and distance pipeline: fixed latency,
// no spurious responses, coincident and distance consistency.
// ---------------------------------------------------------------------------
module ppad_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input ppad_pkg::ppad_rsp_type rsp_word
);

   // every accepted word comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ppad_pkg::LATENCY) rsp_strobe)
      else $error("accepted word gave no response after the pipeline latency");

   // no response without a word accepted that far back
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, ppad_pkg::LATENCY))
      else $error("response strobe without a matching accepted word");

   // coincident points give zero angle and zero distance
   a_coincident: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.coincident) |->
         (rsp_word.angle == '0 && rsp_word.distance == '0))
      else $error("coincident response with non-zero angle or distance");

   // distinct points are at least one unit apart
   a_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.coincident) |-> (rsp_word.distance != '0))
      else $error("zero distance on distinct points");

   // reset empties the pipeline: nothing at the first edge after release
   a_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_strobe)
      else $error("response strobe straight after reset");

endmodule

bind point_pair_angle_and_distance ppad_checker u_ppad_checker (.*);

>>> dv/ppad_direction_checker.sv
// ---------------------------------------------------------------------------
// ppad_direction_checker
// Watches the request, response and csr ports of the point pair angle and
// distance block, predicts each response from the accepted request word and
// the current angle unit, and compares responses in order, field by field.
// ---------------------------------------------------------------------------
module ppad_direction_checker
   import ppad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  ppad_req_type req_word,
   input  logic         rsp_strobe,
   input  ppad_rsp_type rsp_word,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   output int           fail_count,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // arctangent of 2^-i, in 2^-32 turn
   localparam logic [0:31][31:0] ATAN_STEP = {
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // larger magnitude is brought up to at least this before rotating
   localparam longint NORM_FLOOR = 64'sd1 << 40;

   // turn to radians: 2pi in Q29, result in Q3.13, rounded half up
   localparam int         TURN_TO_RAD_SH = 61 - ANGLE_FRAC_BITS;
   localparam logic [64:0] RAD_SCALE     = 65'd3373259426;
   localparam logic [64:0] RAD_HALF      = 65'd1 << (TURN_TO_RAD_SH - 1);
   localparam logic [64:0] RAD_WRAP      =
      ((65'd1 << 32) * RAD_SCALE + RAD_HALF) >> TURN_TO_RAD_SH;

   // turn to degrees: 360 = 45 << 3, result in Q9.7
   localparam int         TURN_TO_DEG_SH = 29 - (ANGLE_FRAC_BITS - 6);
   localparam logic [64:0] DEG_SCALE     = 65'd45;
   localparam logic [64:0] DEG_HALF      = 65'd1 << (TURN_TO_DEG_SH - 1);
   localparam logic [64:0] DEG_WRAP      = ((65'd1 << 32) * DEG_SCALE) >> TURN_TO_DEG_SH;

   ppad_rsp_type pending_rsp_q[$];
   logic         unit_sel;

   // rounded euclidean distance: floor root by bit search, then round
   function automatic longint rounded_distance(input longint ax, input longint ay);
      longint sum_sq;
      longint root;
      longint cand;
      sum_sq = ax * ax + ay * ay;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         cand = root | (64'sd1 << b);
         if (cand * cand <= sum_sq)
            root = cand;
      end
      if (sum_sq - root * root > root)
         root++;
      if (root > 131071)
         root = 131071;
      return root;
   endfunction

   // direction and distance of the point as seen from the origin
   function automatic ppad_rsp_type predict_direction(input ppad_req_type w,
                                                      input logic unit_now);
      longint       dx;
      longint       up;
      longint       ax;
      longint       ay;
      longint       big;
      longint       x;
      longint       y;
      longint       xs;
      longint       ys;
      int           sh;
      logic [31:0]  turns;
      logic [64:0]  scaled;
      ppad_rsp_type res;
      res = '0;
      dx = longint'(w.point_x) - longint'(w.origin_x);
      up = longint'(w.origin_y) - longint'(w.point_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (up < 0) ? -up : up;

      // coincident points: no direction
      if (ax == 0 && ay == 0) begin
         res.coincident = 1'b1;
         return res;
      end
      res.distance = DIST_BITS'(rounded_distance(ax, ay));

      // fold the left half plane onto the right, starting half a turn round
      x = dx;
      y = up;
      turns = 32'h0;
      if (dx < 0) begin
         x = -dx;
         y = -up;
         turns = 32'h8000_0000;
      end

      // normalise magnitude
      big = (ax > ay) ? ax : ay;
      sh = 0;
      while ((big << sh) < NORM_FLOOR)
         sh++;
      x = x <<< sh;
      y = y <<< sh;

      // vectoring rotations, floor shifts, wrapping angle accumulator
      for (int i = 0; i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            turns = turns + ATAN_STEP[i];
         end else begin
            x = x - ys;
            y = y + xs;
            turns = turns - ATAN_STEP[i];
         end
      end

      // binary turn to output unit, a full turn reads as zero
      if (unit_now == UNIT_RADIANS) begin
         scaled = ({33'd0, turns} * RAD_SCALE + RAD_HALF) >> TURN_TO_RAD_SH;
         if (scaled >= RAD_WRAP)
            scaled = '0;
      end else begin
         scaled = ({33'd0, turns} * DEG_SCALE + DEG_HALF) >> TURN_TO_DEG_SH;
         if (scaled >= DEG_WRAP)
            scaled = '0;
      end
      res.angle = scaled[ANGLE_BITS-1:0];
      return res;
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // response check first, then capture of the request word and csr write
   always @(posedge clock) begin : watch
      ppad_rsp_type want;
      if (reset) begin
         pending_rsp_q.delete();
         unit_sel = UNIT_RADIANS;
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp_q.size() == 0) begin
               report_mismatch("response word with none pending", 64'sd1, 64'sd0);
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_word.angle !== want.angle)
                  report_mismatch("angle", longint'(rsp_word.angle),
                                  longint'(want.angle));
               if (rsp_word.distance !== want.distance)
                  report_mismatch("distance", longint'(rsp_word.distance),
                                  longint'(want.distance));
               if (rsp_word.coincident !== want.coincident)
                  report_mismatch("coincident", longint'(rsp_word.coincident),
                                  longint'(want.coincident));
            end
         end
         if (start && !busy)
            pending_rsp_q.push_back(predict_direction(req_word, unit_sel));
         if (csr_wr_en)
            unit_sel = csr_wr_data;
      end
      outstanding = pending_rsp_q.size();
   end

endmodule

>>> dv/tb_point_pair_angle_and_distance.sv
// ---------------------------------------------------------------------------
// tb_point_pair_angle_and_distance
// Drives request words into the angle and distance block in random bursts,
// in both angle units, after a directed set of axes, diagonals, extremes and
// coincident points; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_point_pair_angle_and_distance;
   timeunit 1ns;
   timeprecision 1ps;

   import ppad_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RANDOM_WORDS  = 1750;
   localparam int RANDOM_PHASES = 6;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         start       = 1'b0;
   logic         busy;
   ppad_req_type req_word    = '0;
   logic         rsp_strobe;
   ppad_rsp_type rsp_word;
   logic         csr_wr_en   = 1'b0;
   logic         csr_wr_data = UNIT_RADIANS;
   int           fail_count;
   int           outstanding;

   always #HALF_PERIOD clock = ~clock;

   point_pair_angle_and_distance uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ppad_direction_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic ppad_req_type make_word(input int px, input int py,
                                              input int ox, input int oy);
      ppad_req_type w;
      w.point_x  = px[15:0];
      w.point_y  = py[15:0];
      w.origin_x = ox[15:0];
      w.origin_y = oy[15:0];
      return w;
   endfunction

   // one of the coordinate extremes and their neighbours of zero
   function automatic logic [15:0] edge_coord();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'hFFFF;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   // free coordinates, plus near, axial, diagonal, coincident and edge-value pairs
   function automatic ppad_req_type random_word();
      ppad_req_type w;
      logic [15:0]  off_x;
      logic [15:0]  off_y;
      w = ppad_req_type'({$urandom, $urandom});
      off_x = 16'($urandom_range(0, 16)) - 16'd8;
      off_y = 16'($urandom_range(0, 16)) - 16'd8;
      case ($urandom_range(0, 9))
         4, 5: begin
            w.point_x = w.origin_x + off_x;
            w.point_y = w.origin_y + off_y;
         end
         6: begin
            if ($urandom_range(0, 1))
               w.point_x = w.origin_x;
            else
               w.point_y = w.origin_y;
         end
         7: begin
            w.point_x = w.origin_x;
            w.point_y = w.origin_y;
         end
         8: begin
            off_x = 16'($urandom_range(1, 20000));
            w.point_x = w.origin_x + ($urandom_range(0, 1) ? off_x : -off_x);
            w.point_y = w.origin_y + ($urandom_range(0, 1) ? off_x : -off_x);
         end
         9: begin
            w.point_x  = edge_coord();
            w.point_y  = edge_coord();
            w.origin_x = edge_coord();
            w.origin_y = edge_coord();
         end
         default: ;
      endcase
      return w;
   endfunction

   // present a word and hold it until the block takes it
   task automatic push_word(input ppad_req_type w);
      start    <= 1'b1;
      req_word <= w;
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // unit change only with the pipeline empty
   task automatic set_unit(input logic value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // watchdog
   initial begin
      #8_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      ppad_req_type corner[13];
      int           quota;
      int           sent;
      int           burst;
      int           waited;
      bit           paused;

      // axes, diagonals, extremes, coincident points, wrap just below a turn
      corner[0]  = make_word(0, 0, 0, 0);
      corner[1]  = make_word(-32768, 32767, -32768, 32767);
      corner[2]  = make_word(1, 0, 0, 0);
      corner[3]  = make_word(0, -100, 0, 0);
      corner[4]  = make_word(-32768, 0, 32767, 0);
      corner[5]  = make_word(0, 100, 0, 0);
      corner[6]  = make_word(50, -50, 0, 0);
      corner[7]  = make_word(-50, -50, 0, 0);
      corner[8]  = make_word(-50, 50, 0, 0);
      corner[9]  = make_word(50, 50, 0, 0);
      corner[10] = make_word(32767, -32768, -32768, 32767);
      corner[11] = make_word(-32768, 32767, 32767, -32768);
      corner[12] = make_word(32767, 1, -32768, 0);

      // reset
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words in both units
      set_unit(UNIT_RADIANS);
      foreach (corner[i])
         push_word(corner[i]);
      set_unit(UNIT_DEGREES);
      foreach (corner[i])
         push_word(corner[i]);

      // random bursts, unit alternating per phase
      paused = 1'b0;
      quota = RANDOM_WORDS / RANDOM_PHASES;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_unit((phase % 2 == 0) ? UNIT_RADIANS : UNIT_DEGREES);
         sent = 0;
         while (sent < quota) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < quota; k++) begin
               push_word(random_word());
               sent++;
            end
            if ($urandom_range(0, 3) != 0)
               idle_cycles($urandom_range(1, 45));
            // let the pipeline empty completely once mid phase
            if (phase == 2 && !paused && sent >= quota / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      // drain, then wait with start held low before the final check
      start <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < 8 * LATENCY) begin
         @(negedge clock);
         waited++;
      end
      repeat (LATENCY + 4) @(negedge clock);
      if (outstanding != 0)
         $display("%0d expected response words never arrived", outstanding);

      if (fail_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
